// ===== design/frli_pkg.sv =====
// Package: shared types and constants for the flash ring log indexer
`timescale 1ns / 1ps
package frli_pkg;

	localparam int INDEX_BITS = 16;
	localparam int IDX_W = 16;
	localparam int CNT_W = $clog2(IDX_W);
	localparam int ADDR_W = 24;
	localparam int BYTES_W = 17;
	localparam int GEOM_W = 9;
	localparam int OCC_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [17:0] CAP_LIMIT = (INDEX_BITS >= 16) ? 18'd65536 : 18'(1 << INDEX_BITS);

	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BYTES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_PER_SECTOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT = 3'd4;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_LOCATE = 2'd1,
		ACT_ERASE  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		DIV_HEAD  = 2'd0,
		DIV_TAIL  = 2'd1,
		DIV_ENTRY = 2'd2
	} div_sel_t;

	typedef struct packed {
		action_t           action;
		logic [IDX_W-1:0]  entry_number;
	} frli_in_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] flash_address;
		logic              erase_request;
		logic [ADDR_W-1:0] erase_address;
		logic [OCC_W-1:0]  occupied;
	} frli_out_t;

	typedef struct packed {
		logic     load;
		logic     cap;
		logic     clamp;
		logic     div_start;
		div_sel_t div_sel;
		logic     wb_head;
		logic     wb_tail;
		logic     mul;
		logic     commit;
	} frli_ctl_t;

	typedef struct packed {
		action_t act;
		logic    head_ge_cap;
		logic    tail_ge_cap;
		logic    full;
		logic    out_of_range;
		logic    div_busy;
		logic    rsp_free;
	} frli_sts_t;

endpackage

// ===== design/flash_ring_log_indexer.sv =====
// Top level: flash ring log indexer, controller plus datapath
// Use:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one request: append at head,
//   locate entry N from tail, or erase the tail sector.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result per request:
//   status, entry flash address, erase request and sector address, occupancy.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the geometry;
//   always ready, write only while no request is in flight.
// Sequence:
//   Append, locate and erase each run an entry division in the divider;
//   a full, out-of-range or unknown request skips it. Each head
//   or tail reduction after a geometry change adds a divider pass. The
//   restoring divider has 16 steps; one request at a time.
// Reset:
//   Head, tail and occupancy clear; geometry returns to one 65536-byte sector
//   of 256 entries of 256 bytes at address zero.
// Stall:
//   A result waits in the response register; the next request is taken
//   meanwhile and holds in its final step until that register frees.
`timescale 1ns / 1ps
module flash_ring_log_indexer
	import frli_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  frli_in_t              cmd,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output frli_out_t             rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	frli_ctl_t ctl;
	frli_sts_t sts;

	frli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	frli_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule

// ===== design/frli_div.sv =====
// Restoring divider: one quotient bit per cycle, quotient and remainder held after
`timescale 1ns / 1ps
module frli_div
	import frli_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [IDX_W-1:0]    dividend,
	input  logic [OCC_W-1:0]    divisor,
	output logic                busy,
	output logic [IDX_W-1:0]    quotient,
	output logic [OCC_W-1:0]    remainder
);

	logic [OCC_W-1:0] rem_q;
	logic [IDX_W-1:0] quo_q;
	logic [OCC_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [OCC_W:0]   trial;
	logic [OCC_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[IDX_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && cnt_q == CNT_W'(IDX_W - 1)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
			cnt_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[OCC_W-1:0] : trial[OCC_W-1:0];
			quo_q <= {quo_q[IDX_W-2:0], ge};
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== design/frli_ctrl.sv =====
// Controller: sequences normalisation, index split, address build and result hand-off
`timescale 1ns / 1ps
module frli_ctrl
	import frli_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  frli_sts_t sts,
	output frli_ctl_t ctl
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_CAP   = 10'b0000000010,
		S_CLAMP = 10'b0000000100,
		S_HDIV  = 10'b0000001000,
		S_TCHK  = 10'b0000010000,
		S_TDIV  = 10'b0000100000,
		S_SEL   = 10'b0001000000,
		S_EDIV  = 10'b0010000000,
		S_MUL   = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign cmd_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.div_sel = DIV_HEAD;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d = S_CAP;
				end
			end
			S_CAP: begin
				ctl.cap = 1'b1;
				state_d = S_CLAMP;
			end
			S_CLAMP: begin
				ctl.clamp = 1'b1;
				if (sts.head_ge_cap) begin
					ctl.div_start = 1'b1;
					ctl.div_sel = DIV_HEAD;
					state_d = S_HDIV;
				end else begin
					state_d = S_TCHK;
				end
			end
			S_HDIV: begin
				if (!sts.div_busy) begin
					ctl.wb_head = 1'b1;
					state_d = S_TCHK;
				end
			end
			S_TCHK: begin
				if (sts.tail_ge_cap) begin
					ctl.div_start = 1'b1;
					ctl.div_sel = DIV_TAIL;
					state_d = S_TDIV;
				end else begin
					state_d = S_SEL;
				end
			end
			S_TDIV: begin
				if (!sts.div_busy) begin
					ctl.wb_tail = 1'b1;
					state_d = S_SEL;
				end
			end
			S_SEL: begin
				priority if (sts.act == ACT_NONE
						|| (sts.act == ACT_APPEND && sts.full)
						|| (sts.act == ACT_LOCATE && sts.out_of_range)) begin
					state_d = S_DONE;
				end else begin
					ctl.div_start = 1'b1;
					ctl.div_sel = DIV_ENTRY;
					state_d = S_EDIV;
				end
			end
			S_EDIV: begin
				if (!sts.div_busy) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				ctl.mul = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.rsp_free) begin
					ctl.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/frli_dp.sv =====
// Datapath: geometry registers, ring state, divider, address arithmetic, response register
`timescale 1ns / 1ps
module frli_dp
	import frli_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  frli_in_t              cmd,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output frli_out_t             rsp,
	input  frli_ctl_t             ctl,
	output frli_sts_t             sts
);

	logic [ADDR_W-1:0]  flash_base_q;
	logic [BYTES_W-1:0] sector_bytes_q;
	logic [BYTES_W-1:0] entry_bytes_q;
	logic [GEOM_W-1:0]  eps_q;
	logic [GEOM_W-1:0]  sc_q;

	logic [IDX_W-1:0]   head_q;
	logic [IDX_W-1:0]   tail_q;
	logic [OCC_W-1:0]   used_q;
	logic [OCC_W-1:0]   cap_q;
	action_t            act_q;
	logic [IDX_W-1:0]   num_q;
	logic [ADDR_W-1:0]  sect_prod_q;
	logic [ADDR_W-1:0]  off_prod_q;
	frli_out_t          rsp_q;
	logic               rsp_valid_q;

	logic [GEOM_W-1:0]  eps_eff;
	logic [GEOM_W-1:0]  sc_eff;
	logic [17:0]        cap_prod;
	logic [OCC_W-1:0]   cap_next;
	logic [OCC_W-1:0]   loc_sum;
	logic [OCC_W-1:0]   loc_wrap;
	logic [IDX_W-1:0]   loc_idx;
	logic [IDX_W-1:0]   div_dividend;
	logic [OCC_W-1:0]   div_divisor;
	logic               div_busy;
	logic [IDX_W-1:0]   div_quo;
	logic [OCC_W-1:0]   div_rem;
	logic [32:0]        sect_full;
	logic [25:0]        off_full;
	logic [ADDR_W-1:0]  sector_base;
	logic [ADDR_W-1:0]  entry_addr;
	logic [OCC_W-1:0]   head_inc;
	logic [OCC_W-1:0]   left_eps;
	logic [OCC_W-1:0]   left_end;
	logic [OCC_W-1:0]   left_a;
	logic [OCC_W-1:0]   left;
	logic [OCC_W-1:0]   tail_sum;
	frli_out_t          rsp_next;
	logic [IDX_W-1:0]   head_next;
	logic [IDX_W-1:0]   tail_next;
	logic [OCC_W-1:0]   used_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_base_q   <= '0;
			sector_bytes_q <= 17'd65536;
			entry_bytes_q  <= 17'd256;
			eps_q          <= 9'd256;
			sc_q           <= 9'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FLASH_BASE:         flash_base_q   <= cfg_data[ADDR_W-1:0];
				CFG_SECTOR_BYTES:       sector_bytes_q <= cfg_data[BYTES_W-1:0];
				CFG_ENTRY_BYTES:        entry_bytes_q  <= cfg_data[BYTES_W-1:0];
				CFG_ENTRIES_PER_SECTOR: eps_q          <= cfg_data[GEOM_W-1:0];
				CFG_SECTOR_COUNT:       sc_q           <= cfg_data[GEOM_W-1:0];
				default: ;
			endcase
		end
	end

	assign eps_eff  = (eps_q == '0) ? GEOM_W'(1) : eps_q;
	assign sc_eff   = (sc_q == '0) ? GEOM_W'(1) : sc_q;
	assign cap_prod = 18'(eps_eff) * 18'(sc_eff);
	assign cap_next = (cap_prod > CAP_LIMIT) ? CAP_LIMIT[OCC_W-1:0] : cap_prod[OCC_W-1:0];

	assign loc_sum  = {1'b0, tail_q} + {1'b0, num_q};
	assign loc_wrap = loc_sum - cap_q;
	assign loc_idx  = (loc_sum >= cap_q) ? loc_wrap[IDX_W-1:0] : loc_sum[IDX_W-1:0];

	always_comb begin
		div_dividend = tail_q;
		div_divisor  = cap_q;
		unique case (ctl.div_sel)
			DIV_HEAD: begin
				div_dividend = head_q;
			end
			DIV_TAIL: begin
				div_dividend = tail_q;
			end
			DIV_ENTRY: begin
				div_divisor = {{(OCC_W-GEOM_W){1'b0}}, eps_eff};
				unique case (act_q)
					ACT_APPEND: div_dividend = head_q;
					ACT_LOCATE: div_dividend = loc_idx;
					default:    div_dividend = tail_q;
				endcase
			end
			default: ;
		endcase
	end

	frli_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign sect_full   = 33'(div_quo) * 33'(sector_bytes_q);
	assign off_full    = 26'(div_rem[GEOM_W-1:0]) * 26'(entry_bytes_q);
	assign sector_base = flash_base_q + sect_prod_q;
	assign entry_addr  = sector_base + off_prod_q;

	assign head_inc = {1'b0, head_q} + OCC_W'(1);
	assign left_eps = {{(OCC_W-GEOM_W){1'b0}}, eps_eff} - div_rem;
	assign left_end = cap_q - {1'b0, tail_q};
	assign left_a   = (left_eps > left_end) ? left_end : left_eps;
	assign left     = (left_a > used_q) ? used_q : left_a;
	assign tail_sum = {1'b0, tail_q} + left;

	always_comb begin
		rsp_next  = '0;
		rsp_next.status = ST_OK;
		head_next = head_q;
		tail_next = tail_q;
		used_next = used_q;
		unique case (act_q)
			ACT_APPEND: begin
				if (used_q >= cap_q) begin
					rsp_next.status = ST_FULL;
				end else begin
					rsp_next.flash_address = entry_addr;
					if (div_rem == '0) begin
						rsp_next.erase_request = 1'b1;
						rsp_next.erase_address = sector_base;
					end
					head_next = (head_inc == cap_q) ? '0 : head_inc[IDX_W-1:0];
					used_next = used_q + OCC_W'(1);
				end
			end
			ACT_LOCATE: begin
				if ({1'b0, num_q} >= used_q) begin
					rsp_next.status = ST_RANGE;
				end else begin
					rsp_next.flash_address = entry_addr;
				end
			end
			ACT_ERASE: begin
				rsp_next.erase_request = 1'b1;
				rsp_next.erase_address = sector_base;
				tail_next = (tail_sum == cap_q) ? '0 : tail_sum[IDX_W-1:0];
				used_next = used_q - left;
			end
			default: ;
		endcase
		rsp_next.occupied = used_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.clamp && used_q > cap_q) begin
				used_q <= cap_q;
			end
			if (ctl.wb_head) begin
				head_q <= div_rem[IDX_W-1:0];
			end
			if (ctl.wb_tail) begin
				tail_q <= div_rem[IDX_W-1:0];
			end
			if (ctl.commit) begin
				head_q <= head_next;
				tail_q <= tail_next;
				used_q <= used_next;
			end
			if (ctl.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			act_q <= cmd.action;
			num_q <= cmd.entry_number;
		end
		if (ctl.cap) begin
			cap_q <= cap_next;
		end
		if (ctl.mul) begin
			sect_prod_q <= sect_full[ADDR_W-1:0];
			off_prod_q  <= off_full[ADDR_W-1:0];
		end
		if (ctl.commit) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		sts.act          = act_q;
		sts.head_ge_cap  = {1'b0, head_q} >= cap_q;
		sts.tail_ge_cap  = {1'b0, tail_q} >= cap_q;
		sts.full         = used_q >= cap_q;
		sts.out_of_range = {1'b0, num_q} >= used_q;
		sts.div_busy     = div_busy;
		sts.rsp_free     = !rsp_valid_q || rsp_ready;
	end

endmodule
